@@ design/sfat_pkg.sv @@
// ----------------------------------------------------------------------------
// sfat_pkg
// Shared constants, operation codes and status codes for the swap frame
// allocator and translator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfat_pkg;

    // Geometry (PAGE_WORDS must be a power of two)
    localparam int PAGE_WORDS     = 8;
    localparam int SWAP_FRAMES    = 64;
    localparam int MAX_PROCESSES  = 16;
    localparam int MAX_PAGES      = 16;

    // Field widths fixed by the interface
    localparam int OP_W    = 2;
    localparam int PID_W   = 4;
    localparam int OFF_W   = 7;
    localparam int SIZE_W  = 8;
    localparam int ST_W    = 2;
    localparam int ADDR_W  = 9;
    localparam int PAGES_W = 5;

    // Derived widths
    localparam int PAGE_SHIFT = $clog2(PAGE_WORDS);
    localparam int FRAME_W    = (SWAP_FRAMES > 1) ? $clog2(SWAP_FRAMES) : 1;
    localparam int PG_W       = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int TBL_DEPTH  = MAX_PROCESSES * MAX_PAGES;
    localparam int TBL_AW     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int NEED_W     = SIZE_W + 1 - PAGE_SHIFT;
    localparam int WORD_W     = SIZE_W + 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_REL   = 2'd1;
    localparam logic [OP_W-1:0] OP_TR_I  = 2'd2;
    localparam logic [OP_W-1:0] OP_TR_D  = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [ST_W-1:0] ST_REGION  = 2'd2;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd3;

endpackage

`default_nettype wire

@@ design/swap_frame_allocator_translator_core.sv @@
// ----------------------------------------------------------------------------
// swap_frame_allocator_translator_core
// First-fit swap frame allocator with a per-process frame table and word
// address translation, run by a small sequencer around one frame table RAM.
// ----------------------------------------------------------------------------
// Flow: allocate first releases any pages held, then claims need frames
//   (need <= 16); a claim that runs dry rolls back the frames it took.
// Throughput: one transaction at a time, busy until the result strobe; release
//   walks the table one page a cycle, claims take one frame a cycle.
// Reset: synchronous, active low; all frames free; result strobe never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_frame_allocator_translator_core
    import sfat_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic [PID_W-1:0]   i_process_id,
    input  wire logic [OFF_W-1:0]   i_word_offset,
    input  wire logic [SIZE_W-1:0]  i_mem_words,
    input  wire logic [SIZE_W-1:0]  i_instr_words,
    output logic                    o_valid,
    output logic [ST_W-1:0]         o_status,
    output logic [ADDR_W-1:0]       o_swap_address,
    output logic [PAGES_W-1:0]      o_pages_allocated
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_REL   = 3'd1;
    localparam logic [2:0] S_CLAIM = 3'd2;
    localparam logic [2:0] S_TRANS = 3'd3;
    localparam logic [2:0] S_TR_RD = 3'd4;

    // Lowest free frame
    function automatic logic [FRAME_W-1:0] lowest_free(input logic [SWAP_FRAMES-1:0] m);
        logic [FRAME_W-1:0] idx;
        idx = '0;
        for (int i = SWAP_FRAMES - 1; i >= 0; i--) begin
            if (m[i]) idx = FRAME_W'(i);
        end
        return idx;
    endfunction

    // Frame table address of a process page
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [PID_W-1:0] p,
                                                    input logic [PG_W-1:0] pg);
        return TBL_AW'(int'(p) * MAX_PAGES + int'(pg));
    endfunction

    // Control and request registers
    logic [2:0]             r_state,  n_state;
    logic [OP_W-1:0]        r_op,     n_op;
    logic [PID_W-1:0]       r_pid,    n_pid;
    logic [OFF_W-1:0]       r_off,    n_off;
    logic [SIZE_W-1:0]      r_msize,  n_msize;
    logic [SIZE_W-1:0]      r_ninstr, n_ninstr;
    logic [NEED_W-1:0]      r_need,   n_need;
    logic [CNT_W-1:0]       r_k,      n_k;
    logic [CNT_W-1:0]       r_n,      n_n;
    logic [CNT_W-1:0]       r_j,      n_j;
    logic                   r_rd_vld, n_rd_vld;
    logic                   r_fail,   n_fail;
    logic [WORD_W-1:0]      r_w,      n_w;
    logic [SWAP_FRAMES-1:0] r_free,   n_free;

    // Result registers
    logic                   r_valid,  n_valid;
    logic [ST_W-1:0]        r_status, n_status;
    logic [ADDR_W-1:0]      r_addr,   n_addr;
    logic [PAGES_W-1:0]     r_pages,  n_pages;

    // Per-process records
    logic [CNT_W-1:0]       r_cnt   [MAX_PROCESSES];
    logic [SIZE_W-1:0]      r_bound [MAX_PROCESSES];
    logic [SIZE_W-1:0]      r_db    [MAX_PROCESSES];

    // Frame table RAM
    logic [FRAME_W-1:0]     r_tbl   [TBL_DEPTH];
    logic [FRAME_W-1:0]     r_rdata;
    logic                   tbl_we;
    logic [TBL_AW-1:0]      tbl_waddr;
    logic [FRAME_W-1:0]     tbl_wdata;
    logic [TBL_AW-1:0]      tbl_raddr;

    logic                   proc_clr;
    logic                   proc_set;

    // Translation datapath
    logic [SIZE_W-1:0]      e_instr;
    logic [WORD_W-1:0]      w_data;
    logic [WORD_W-1:0]      e_data;
    logic [WORD_W-1:0]      w_sel;
    logic [WORD_W-PAGE_SHIFT-1:0] page_sel;
    logic [FRAME_W-1:0]     ff_idx;

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_swap_address    = r_addr;
    assign o_pages_allocated = r_pages;

    assign e_instr  = SIZE_W'(r_off) + SIZE_W'(1);
    assign w_data   = WORD_W'(r_off) + WORD_W'(r_db[r_pid]);
    assign e_data   = w_data + WORD_W'(1);
    assign w_sel    = (r_op == OP_TR_I) ? WORD_W'(r_off) : w_data;
    assign page_sel = w_sel[WORD_W-1:PAGE_SHIFT];
    assign ff_idx   = lowest_free(r_free);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_pid    = r_pid;
        n_off    = r_off;
        n_msize  = r_msize;
        n_ninstr = r_ninstr;
        n_need   = r_need;
        n_k      = r_k;
        n_n      = r_n;
        n_j      = r_j;
        n_rd_vld = 1'b0;
        n_fail   = r_fail;
        n_w      = r_w;
        n_free   = r_free;
        n_valid  = 1'b0;
        n_status = r_status;
        n_addr   = r_addr;
        n_pages  = r_pages;
        tbl_we    = 1'b0;
        tbl_waddr = '0;
        tbl_wdata = '0;
        tbl_raddr = '0;
        proc_clr  = 1'b0;
        proc_set  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = i_operation;
                    n_pid    = i_process_id;
                    n_off    = i_word_offset;
                    n_msize  = i_mem_words;
                    n_ninstr = i_instr_words;
                    n_need   = NEED_W'(({1'b0, i_mem_words} + (SIZE_W+1)'(PAGE_WORDS - 1))
                                       >> PAGE_SHIFT);
                    n_k      = '0;
                    n_n      = r_cnt[i_process_id];
                    n_fail   = 1'b0;
                    if (int'(i_process_id) >= MAX_PROCESSES) begin
                        n_valid  = 1'b1;
                        n_status = ST_OUTSIDE;
                        n_addr   = '0;
                        n_pages  = '0;
                    end else if (i_operation == OP_ALLOC || i_operation == OP_REL) begin
                        n_state = S_REL;
                    end else begin
                        n_state = S_TRANS;
                    end
                end
            end

            // Walk the process's pages and return each frame to the free map
            S_REL: begin
                if (r_k < r_n) begin
                    tbl_raddr = tbl_addr(r_pid, r_k[PG_W-1:0]);
                    n_k       = r_k + CNT_W'(1);
                    n_rd_vld  = 1'b1;
                end
                if (r_rd_vld && ({1'b0, r_rdata} < (FRAME_W+1)'(SWAP_FRAMES))) begin
                    n_free[r_rdata] = 1'b1;
                end
                if (r_k == r_n && !r_rd_vld) begin
                    proc_clr = 1'b1;
                    if (r_fail || r_op == OP_REL ||
                        int'(r_need) > MAX_PAGES) begin
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_status = (r_op == OP_REL) ? ST_OK : ST_NOSPACE;
                        n_addr   = '0;
                        n_pages  = '0;
                    end else begin
                        n_state = S_CLAIM;
                        n_j     = '0;
                    end
                end
            end

            // Claim one frame a cycle; roll back if the free map runs dry
            S_CLAIM: begin
                if (int'(r_j) == int'(r_need)) begin
                    proc_set = 1'b1;
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_addr   = '0;
                    n_pages  = PAGES_W'(r_need);
                end else if (|r_free) begin
                    n_free[ff_idx] = 1'b0;
                    tbl_we    = 1'b1;
                    tbl_waddr = tbl_addr(r_pid, r_j[PG_W-1:0]);
                    tbl_wdata = ff_idx;
                    n_j       = r_j + CNT_W'(1);
                end else begin
                    n_state = S_REL;
                    n_k     = '0;
                    n_n     = r_j;
                    n_fail  = 1'b1;
                end
            end

            // Bound and region checks, then look up the page's frame
            S_TRANS: begin
                n_w = w_sel;
                if ((r_op == OP_TR_I && e_instr > r_bound[r_pid]) ||
                    (r_op == OP_TR_D && e_data > WORD_W'(r_bound[r_pid]))) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_OUTSIDE;
                    n_addr   = '0;
                    n_pages  = '0;
                end else if (r_op == OP_TR_I && e_instr > r_db[r_pid]) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_REGION;
                    n_addr   = '0;
                    n_pages  = '0;
                end else if (int'(page_sel) < MAX_PAGES) begin
                    tbl_raddr = tbl_addr(r_pid, PG_W'(page_sel));
                    n_state   = S_TR_RD;
                end else begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_addr   = ADDR_W'(w_sel[PAGE_SHIFT-1:0]);
                    n_pages  = '0;
                end
            end

            S_TR_RD: begin
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_addr   = ADDR_W'({r_rdata, r_w[PAGE_SHIFT-1:0]});
                n_pages  = '0;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and per-process records
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_fail   <= 1'b0;
            r_valid  <= 1'b0;
            r_free   <= '1;
            r_k      <= '0;
            r_n      <= '0;
            r_j      <= '0;
            for (int i = 0; i < MAX_PROCESSES; i++) begin
                r_cnt[i]   <= '0;
                r_bound[i] <= '0;
                r_db[i]    <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_fail   <= n_fail;
            r_valid  <= n_valid;
            r_free   <= n_free;
            r_k      <= n_k;
            r_n      <= n_n;
            r_j      <= n_j;
            if (proc_clr) begin
                r_cnt[r_pid]   <= '0;
                r_bound[r_pid] <= '0;
                r_db[r_pid]    <= '0;
            end else if (proc_set) begin
                r_cnt[r_pid]   <= CNT_W'(r_need);
                r_bound[r_pid] <= r_msize;
                r_db[r_pid]    <= r_ninstr;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pid    <= n_pid;
        r_off    <= n_off;
        r_msize  <= n_msize;
        r_ninstr <= n_ninstr;
        r_need   <= n_need;
        r_w      <= n_w;
        r_status <= n_status;
        r_addr   <= n_addr;
        r_pages  <= n_pages;
    end

    // Frame table RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wdata;
        end
        r_rdata <= r_tbl[tbl_raddr];
    end

endmodule

`default_nettype wire
